// File: hdl/tfn_pkg.sv
// shared constants, codes and pipeline types of the triangle face normal unit
package tfn_pkg;

   localparam int SCALE_BITS  = 30;
   localparam int SQ_BITS     = 2 * SCALE_BITS;
   localparam int SUM_BITS    = SQ_BITS + 2;
   localparam int ROOT_BITS   = SUM_BITS / 2;
   localparam int FRAC_BITS   = 14;
   localparam int QUO_BITS    = FRAC_BITS + 1;
   localparam int NUM_BITS    = SCALE_BITS + FRAC_BITS + 1;
   localparam int NORM_BITS   = 16;
   localparam int COUNT_BITS  = 11;
   localparam int CORNER_BITS = 12;
   localparam int VADDR_BITS  = 10;

   typedef enum logic {
      REQ_VERTEX   = 1'b0,
      REQ_TRIANGLE = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic valid;
      logic index_error;
      logic degenerate;
      logic last;
   } ctl_type;

   typedef struct packed {
      logic [2:0]                 neg;
      logic [2:0][SCALE_BITS-1:0] mag;
   } vec_type;

endpackage

// File: hdl/triangle_face_normal.sv
// top level of the triangle face normal unit
//
//   channel   ports                    transfer when
//   request   start, busy, req_*       start & !busy
//   response  rsp_valid, rsp_*         rsp_valid (one cycle strobe)
//   csr       csr_valid, csr_ready     csr_valid & csr_ready
//
// one item per cycle; busy stays low, the pipeline never stops
// a triangle result passes the store read, cross and scaling, square root
// (one root bit per stage), divide and the output register in that order;
// vertex writes give no result
// reset clears valid bits and vertex_count, the store is not cleared
// the receiver cannot stall, so there is no backpressure path
module triangle_face_normal #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 20
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic                                    req_type,
   input  logic [tfn_pkg::VADDR_BITS-1:0]          req_vertex_addr,
   input  logic signed [COORD_BITS-1:0]            req_pos_x,
   input  logic signed [COORD_BITS-1:0]            req_pos_y,
   input  logic signed [COORD_BITS-1:0]            req_pos_z,
   input  logic [tfn_pkg::CORNER_BITS-1:0]         req_corner_a,
   input  logic [tfn_pkg::CORNER_BITS-1:0]         req_corner_b,
   input  logic [tfn_pkg::CORNER_BITS-1:0]         req_corner_c,
   input  logic                                    req_last_in,
   output logic                                    rsp_valid,
   output logic signed [tfn_pkg::NORM_BITS-1:0]    rsp_normal_x,
   output logic signed [tfn_pkg::NORM_BITS-1:0]    rsp_normal_y,
   output logic signed [tfn_pkg::NORM_BITS-1:0]    rsp_normal_z,
   output logic                                    rsp_index_error,
   output logic                                    rsp_degenerate,
   output logic                                    rsp_last_out,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [tfn_pkg::COUNT_BITS-1:0]          csr_data
);
   import tfn_pkg::*;

   localparam int AB = $clog2(MAX_VERTICES);

   logic                        accept, wr_en, rd_en;
   logic [2:0][COORD_BITS-1:0]  wr_pos, va, vb, vc;
   logic [COUNT_BITS-1:0]       vertex_count_in, vertex_count_ff;
   ctl_type                     st_ctl, cr_ctl, sq_ctl, dv_ctl;
   vec_type                     cr_vec, sq_vec;
   logic [SUM_BITS-1:0]         cr_sum;
   logic [ROOT_BITS-1:0]        sq_root;
   logic [2:0]                  dv_neg;
   logic [2:0][QUO_BITS-1:0]    dv_quo;
   logic [NORM_BITS-1:0]        nrm_in [3], nrm_ff [3];
   logic                        valid_in, valid_ff;
   logic                        ierr_in, ierr_ff, degen_in, degen_ff, last_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;
   assign wr_en     = accept && (req_type == REQ_VERTEX) &&
                      (32'(req_vertex_addr) < MAX_VERTICES);
   assign rd_en     = accept && (req_type == REQ_TRIANGLE);
   assign wr_pos[0] = req_pos_x;
   assign wr_pos[1] = req_pos_y;
   assign wr_pos[2] = req_pos_z;

   assign vertex_count_in = (csr_valid && csr_ready) ? csr_data : vertex_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   tfn_vstore #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) u_vstore (
      .clock        (clock),
      .reset        (reset),
      .wr_en        (wr_en),
      .wr_addr      (AB'(req_vertex_addr)),
      .wr_pos       (wr_pos),
      .rd_en        (rd_en),
      .corner_a     (req_corner_a),
      .corner_b     (req_corner_b),
      .corner_c     (req_corner_c),
      .last_in      (req_last_in),
      .vertex_count (vertex_count_ff),
      .out_ctl      (st_ctl),
      .out_a        (va),
      .out_b        (vb),
      .out_c        (vc)
   );

   tfn_cross #(
      .COORD_BITS (COORD_BITS)
   ) u_cross (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (st_ctl),
      .in_a    (va),
      .in_b    (vb),
      .in_c    (vc),
      .out_ctl (cr_ctl),
      .out_vec (cr_vec),
      .out_sum (cr_sum)
   );

   tfn_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (cr_ctl),
      .in_vec   (cr_vec),
      .in_sum   (cr_sum),
      .out_ctl  (sq_ctl),
      .out_vec  (sq_vec),
      .out_root (sq_root)
   );

   tfn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (sq_ctl),
      .in_vec  (sq_vec),
      .in_root (sq_root),
      .out_ctl (dv_ctl),
      .out_neg (dv_neg),
      .out_quo (dv_quo)
   );

   // error and degenerate results carry zero normals
   always_comb begin
      valid_in = dv_ctl.valid;
      ierr_in  = dv_ctl.index_error;
      degen_in = dv_ctl.degenerate & ~dv_ctl.index_error;
      for (int i = 0; i < 3; i++) begin
         if (ierr_in || degen_in) begin
            nrm_in[i] = '0;
         end else if (dv_neg[i]) begin
            nrm_in[i] = -NORM_BITS'(dv_quo[i]);
         end else begin
            nrm_in[i] = NORM_BITS'(dv_quo[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         nrm_ff[i] <= nrm_in[i];
      end
      ierr_ff  <= ierr_in;
      degen_ff <= degen_in;
      last_ff  <= dv_ctl.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_normal_x    = nrm_ff[0];
   assign rsp_normal_y    = nrm_ff[1];
   assign rsp_normal_z    = nrm_ff[2];
   assign rsp_index_error = ierr_ff;
   assign rsp_degenerate  = degen_ff;
   assign rsp_last_out    = last_ff;

endmodule

// File: hdl/tfn_vstore.sv
// vertex position store, three read banks, corner index check
module tfn_vstore #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 20
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   wr_en,
   input  logic [$clog2(MAX_VERTICES)-1:0]        wr_addr,
   input  logic [2:0][COORD_BITS-1:0]             wr_pos,
   input  logic                                   rd_en,
   input  logic [tfn_pkg::CORNER_BITS-1:0]        corner_a,
   input  logic [tfn_pkg::CORNER_BITS-1:0]        corner_b,
   input  logic [tfn_pkg::CORNER_BITS-1:0]        corner_c,
   input  logic                                   last_in,
   input  logic [tfn_pkg::COUNT_BITS-1:0]         vertex_count,
   output tfn_pkg::ctl_type                       out_ctl,
   output logic [2:0][COORD_BITS-1:0]             out_a,
   output logic [2:0][COORD_BITS-1:0]             out_b,
   output logic [2:0][COORD_BITS-1:0]             out_c
);
   import tfn_pkg::*;

   localparam int AB = $clog2(MAX_VERTICES);

   logic [2:0][COORD_BITS-1:0] mem_a_ff [MAX_VERTICES];
   logic [2:0][COORD_BITS-1:0] mem_b_ff [MAX_VERTICES];
   logic [2:0][COORD_BITS-1:0] mem_c_ff [MAX_VERTICES];
   logic [2:0][COORD_BITS-1:0] rd_a_ff, rd_b_ff, rd_c_ff;
   ctl_type                    ctl_in, ctl_ff;

   function automatic logic bad_corner(input logic [CORNER_BITS-1:0] idx,
                                       input logic [COUNT_BITS-1:0]  cnt);
      bad_corner = (idx >= {1'b0, cnt}) || (32'(idx) >= MAX_VERTICES);
   endfunction

   always_comb begin
      ctl_in.valid       = rd_en;
      ctl_in.index_error = bad_corner(corner_a, vertex_count) ||
                           bad_corner(corner_b, vertex_count) ||
                           bad_corner(corner_c, vertex_count);
      ctl_in.degenerate  = 1'b0;
      ctl_in.last        = last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a_ff[wr_addr] <= wr_pos;
         mem_b_ff[wr_addr] <= wr_pos;
         mem_c_ff[wr_addr] <= wr_pos;
      end
      rd_a_ff <= mem_a_ff[AB'(corner_a)];
      rd_b_ff <= mem_b_ff[AB'(corner_b)];
      rd_c_ff <= mem_c_ff[AB'(corner_c)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_a   = rd_a_ff;
   assign out_b   = rd_b_ff;
   assign out_c   = rd_c_ff;

endmodule

// File: hdl/tfn_cross.sv
// edge differences, cross product, scaling to 30 bits and sum of squares
module tfn_cross #(
   parameter int COORD_BITS = 20
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tfn_pkg::ctl_type                in_ctl,
   input  logic [2:0][COORD_BITS-1:0]      in_a,
   input  logic [2:0][COORD_BITS-1:0]      in_b,
   input  logic [2:0][COORD_BITS-1:0]      in_c,
   output tfn_pkg::ctl_type                out_ctl,
   output tfn_pkg::vec_type                out_vec,
   output logic [tfn_pkg::SUM_BITS-1:0]    out_sum
);
   import tfn_pkg::*;

   localparam int DW       = COORD_BITS + 1;
   localparam int PW       = 2 * DW;
   localparam int CW       = PW + 1;
   localparam int MB       = CW;
   localparam int LEN_BITS = $clog2(MB + 1);
   localparam int STAGES   = 8;

   logic signed [DW-1:0]      f_in [3], f_ff [3], s_in [3], s_ff [3];
   logic signed [PW-1:0]      p_in [6], p_ff [6];
   logic signed [CW-1:0]      c_in [3], c_ff [3];
   logic [MB-1:0]             mag_in [3], mag_ff [3], mag2_ff [3];
   logic [2:0]                neg_in, neg_ff [4];
   logic [MB-1:0]             or_bits;
   logic [LEN_BITS-1:0]       len_in, len_ff;
   logic [MB+SCALE_BITS-1:0]  pad [3];
   logic [SCALE_BITS-1:0]     m_in [3], m_ff [3], m2_ff [3];
   logic [SQ_BITS-1:0]        sq_in [3], sq_ff [3];
   logic [SUM_BITS-1:0]       sum_in, sum_ff;
   vec_type                   vec_in, vec_ff;
   ctl_type                   ctl_in [STAGES], ctl_ff [STAGES];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         f_in[i] = DW'($signed(in_a[i])) - DW'($signed(in_b[i]));
         s_in[i] = DW'($signed(in_c[i])) - DW'($signed(in_b[i]));
      end
      p_in[0] = PW'(s_ff[1]) * PW'(f_ff[2]);
      p_in[1] = PW'(s_ff[2]) * PW'(f_ff[1]);
      p_in[2] = PW'(s_ff[2]) * PW'(f_ff[0]);
      p_in[3] = PW'(s_ff[0]) * PW'(f_ff[2]);
      p_in[4] = PW'(s_ff[0]) * PW'(f_ff[1]);
      p_in[5] = PW'(s_ff[1]) * PW'(f_ff[0]);
      for (int i = 0; i < 3; i++) begin
         c_in[i]   = CW'(p_ff[2*i]) - CW'(p_ff[2*i+1]);
         neg_in[i] = c_ff[i][CW-1];
         mag_in[i] = neg_in[i] ? MB'(-c_ff[i]) : MB'(c_ff[i]);
      end
      or_bits = mag_ff[0] | mag_ff[1] | mag_ff[2];
      len_in  = '0;
      for (int b = 0; b < MB; b++) begin
         if (or_bits[b]) begin
            len_in = LEN_BITS'(b + 1);
         end
      end
      for (int i = 0; i < 3; i++) begin
         pad[i]   = {mag2_ff[i], {SCALE_BITS{1'b0}}} >> len_ff;
         m_in[i]  = pad[i][SCALE_BITS-1:0];
         sq_in[i] = SQ_BITS'(m_ff[i]) * SQ_BITS'(m_ff[i]);
      end
      sum_in = SUM_BITS'(sq_ff[0]) + SUM_BITS'(sq_ff[1]) + SUM_BITS'(sq_ff[2]);
      vec_in.neg = neg_ff[3];
      for (int i = 0; i < 3; i++) begin
         vec_in.mag[i] = m2_ff[i];
      end
      ctl_in[0] = in_ctl;
      for (int st = 1; st < STAGES; st++) begin
         ctl_in[st] = ctl_ff[st-1];
      end
      ctl_in[4].degenerate = ~|or_bits;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         f_ff[i]    <= f_in[i];
         s_ff[i]    <= s_in[i];
         c_ff[i]    <= c_in[i];
         mag_ff[i]  <= mag_in[i];
         mag2_ff[i] <= mag_ff[i];
         m_ff[i]    <= m_in[i];
         m2_ff[i]   <= m_ff[i];
         sq_ff[i]   <= sq_in[i];
      end
      for (int i = 0; i < 6; i++) begin
         p_ff[i] <= p_in[i];
      end
      neg_ff[0] <= neg_in;
      for (int st = 1; st < 4; st++) begin
         neg_ff[st] <= neg_ff[st-1];
      end
      len_ff <= len_in;
      sum_ff <= sum_in;
      vec_ff <= vec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int st = 0; st < STAGES; st++) begin
            ctl_ff[st] <= '0;
         end
      end else begin
         for (int st = 0; st < STAGES; st++) begin
            ctl_ff[st] <= ctl_in[st];
         end
      end
   end

   assign out_ctl = ctl_ff[STAGES-1];
   assign out_vec = vec_ff;
   assign out_sum = sum_ff;

endmodule

// File: hdl/tfn_sqrt.sv
// pipelined integer square root, one root bit per stage
module tfn_sqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  tfn_pkg::ctl_type                 in_ctl,
   input  tfn_pkg::vec_type                 in_vec,
   input  logic [tfn_pkg::SUM_BITS-1:0]     in_sum,
   output tfn_pkg::ctl_type                 out_ctl,
   output tfn_pkg::vec_type                 out_vec,
   output logic [tfn_pkg::ROOT_BITS-1:0]    out_root
);
   import tfn_pkg::*;

   logic [SUM_BITS-1:0]  rem_prev [ROOT_BITS], trial [ROOT_BITS];
   logic [SUM_BITS-1:0]  rem_in [ROOT_BITS], rem_ff [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_prev [ROOT_BITS], root_in [ROOT_BITS], root_ff [ROOT_BITS];
   vec_type              vec_in [ROOT_BITS], vec_ff [ROOT_BITS];
   ctl_type              ctl_in [ROOT_BITS], ctl_ff [ROOT_BITS];

   always_comb begin
      for (int j = 0; j < ROOT_BITS; j++) begin
         if (j == 0) begin
            rem_prev[j]  = in_sum;
            root_prev[j] = '0;
            vec_in[j]    = in_vec;
            ctl_in[j]    = in_ctl;
         end else begin
            rem_prev[j]  = rem_ff[j-1];
            root_prev[j] = root_ff[j-1];
            vec_in[j]    = vec_ff[j-1];
            ctl_in[j]    = ctl_ff[j-1];
         end
         trial[j] = (SUM_BITS'(root_prev[j]) << (ROOT_BITS - j)) |
                    (SUM_BITS'(1) << (2 * (ROOT_BITS - 1 - j)));
         rem_in[j]  = rem_prev[j];
         root_in[j] = root_prev[j];
         if (rem_prev[j] >= trial[j]) begin
            rem_in[j]  = rem_prev[j] - trial[j];
            root_in[j] = root_prev[j] | (ROOT_BITS'(1) << (ROOT_BITS - 1 - j));
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < ROOT_BITS; j++) begin
         rem_ff[j]  <= rem_in[j];
         root_ff[j] <= root_in[j];
         vec_ff[j]  <= vec_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < ROOT_BITS; j++) begin
            ctl_ff[j] <= '0;
         end
      end else begin
         for (int j = 0; j < ROOT_BITS; j++) begin
            ctl_ff[j] <= ctl_in[j];
         end
      end
   end

   assign out_ctl  = ctl_ff[ROOT_BITS-1];
   assign out_vec  = vec_ff[ROOT_BITS-1];
   assign out_root = root_ff[ROOT_BITS-1];

endmodule

// File: hdl/tfn_div.sv
// three-lane pipelined rounding divider, one quotient bit per stage
module tfn_div (
   input  logic                                clock,
   input  logic                                reset,
   input  tfn_pkg::ctl_type                    in_ctl,
   input  tfn_pkg::vec_type                    in_vec,
   input  logic [tfn_pkg::ROOT_BITS-1:0]       in_root,
   output tfn_pkg::ctl_type                    out_ctl,
   output logic [2:0]                          out_neg,
   output logic [2:0][tfn_pkg::QUO_BITS-1:0]   out_quo
);
   import tfn_pkg::*;

   logic [NUM_BITS-1:0]  num_in [3], num_ff [3];
   logic [ROOT_BITS-1:0] root_p_ff;
   logic [2:0]           neg_p_ff;
   ctl_type              ctl_p_ff;

   logic [NUM_BITS-1:0]      rem_prev [QUO_BITS][3], rem_in [QUO_BITS][3];
   logic [NUM_BITS-1:0]      rem_ff [QUO_BITS][3], trial [QUO_BITS];
   logic [QUO_BITS-1:0]      quo_prev [QUO_BITS][3], quo_in [QUO_BITS][3];
   logic [QUO_BITS-1:0]      quo_ff [QUO_BITS][3];
   logic [ROOT_BITS-1:0]     root_in [QUO_BITS], root_ff [QUO_BITS];
   logic [2:0]               neg_in [QUO_BITS], neg_ff [QUO_BITS];
   ctl_type                  ctl_in [QUO_BITS], ctl_ff [QUO_BITS];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = (NUM_BITS'(in_vec.mag[i]) << FRAC_BITS) + NUM_BITS'(in_root >> 1);
      end
      for (int j = 0; j < QUO_BITS; j++) begin
         if (j == 0) begin
            root_in[j] = root_p_ff;
            neg_in[j]  = neg_p_ff;
            ctl_in[j]  = ctl_p_ff;
            for (int i = 0; i < 3; i++) begin
               rem_prev[j][i] = num_ff[i];
               quo_prev[j][i] = '0;
            end
         end else begin
            root_in[j] = root_ff[j-1];
            neg_in[j]  = neg_ff[j-1];
            ctl_in[j]  = ctl_ff[j-1];
            for (int i = 0; i < 3; i++) begin
               rem_prev[j][i] = rem_ff[j-1][i];
               quo_prev[j][i] = quo_ff[j-1][i];
            end
         end
         trial[j] = NUM_BITS'(root_in[j]) << (QUO_BITS - 1 - j);
         for (int i = 0; i < 3; i++) begin
            rem_in[j][i] = rem_prev[j][i];
            quo_in[j][i] = quo_prev[j][i];
            if (rem_prev[j][i] >= trial[j]) begin
               rem_in[j][i] = rem_prev[j][i] - trial[j];
               quo_in[j][i] = quo_prev[j][i] | (QUO_BITS'(1) << (QUO_BITS - 1 - j));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         num_ff[i] <= num_in[i];
      end
      root_p_ff <= in_root;
      neg_p_ff  <= in_vec.neg;
      for (int j = 0; j < QUO_BITS; j++) begin
         root_ff[j] <= root_in[j];
         neg_ff[j]  <= neg_in[j];
         for (int i = 0; i < 3; i++) begin
            rem_ff[j][i] <= rem_in[j][i];
            quo_ff[j][i] <= quo_in[j][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_p_ff <= '0;
         for (int j = 0; j < QUO_BITS; j++) begin
            ctl_ff[j] <= '0;
         end
      end else begin
         ctl_p_ff <= in_ctl;
         for (int j = 0; j < QUO_BITS; j++) begin
            ctl_ff[j] <= ctl_in[j];
         end
      end
   end

   assign out_ctl = ctl_ff[QUO_BITS-1];
   assign out_neg = neg_ff[QUO_BITS-1];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_quo[i] = quo_ff[QUO_BITS-1][i];
      end
   end

endmodule

// File: hdl/tfn_checker.sv
// port level checks of the triangle face normal unit and their binding
module tfn_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    busy,
   input logic                                    rsp_valid,
   input logic signed [tfn_pkg::NORM_BITS-1:0]    rsp_normal_x,
   input logic signed [tfn_pkg::NORM_BITS-1:0]    rsp_normal_y,
   input logic signed [tfn_pkg::NORM_BITS-1:0]    rsp_normal_z,
   input logic                                    rsp_index_error,
   input logic                                    rsp_degenerate
);
   import tfn_pkg::*;

   localparam logic signed [NORM_BITS-1:0] ONE     = NORM_BITS'(1 << FRAC_BITS);
   localparam logic signed [NORM_BITS-1:0] NEG_ONE = -ONE;

   // no result can come out of a pipeline that was just flushed
   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid && !busy)
      else $error("result transfer right after reset");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |->
         !rsp_degenerate && rsp_normal_x == 0 && rsp_normal_y == 0 && rsp_normal_z == 0)
      else $error("index error result with nonzero normal");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == 0 && rsp_normal_y == 0 && rsp_normal_z == 0)
      else $error("degenerate result with nonzero normal");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_normal_x <= ONE && rsp_normal_x >= NEG_ONE &&
         rsp_normal_y <= ONE && rsp_normal_y >= NEG_ONE &&
         rsp_normal_z <= ONE && rsp_normal_z >= NEG_ONE)
      else $error("normal component beyond unit range");

endmodule

bind triangle_face_normal tfn_checker u_checker (.*);
